>>> rtl/grsw_pkg.sv
// grid root selection package: widths, constants and sequencer states
`timescale 1ns / 1ps

package grsw_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_BITS   = 24;
  localparam int DIFF_W      = WORD_W + 1;
  localparam int DEN_W       = WORD_W + 2;
  localparam int WEIGHT_W    = 31;
  localparam int MIN_W_W     = 25;
  localparam int SAT_SHIFT   = WEIGHT_W - FRAC_BITS;
  localparam int CNT_W       = 6;
  localparam int IN_DATA_W   = 3 * WORD_W;
  localparam int OUT_DATA_W  = 64;
  localparam int PROD_W      = 2 * WORD_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX       = {WEIGHT_W{1'b1}};
  localparam logic [MIN_W_W-1:0]  MIN_WEIGHT_RESET = MIN_W_W'(168);
  localparam logic [CNT_W-1:0]    WDIV_STEPS       = CNT_W'(WEIGHT_W);
  localparam logic [CNT_W-1:0]    QDIV_STEPS       = CNT_W'(WORD_W);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIFF = 9'b000000010,
    S_WSET = 9'b000000100,
    S_WDIV = 9'b000001000,
    S_WCHK = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_QDIV = 9'b001000000,
    S_POLE = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage

>>> rtl/grid_root_select_by_weight.sv
// grid root search by residual sign change, keeping the root of largest weight
//
//   channel  | direction | handshake                  | payload
//   in_      | slave     | in_tvalid / in_tready      | freq, sigma, residual, tlast = last node
//   out_     | master    | out_tvalid / out_tready    | energy, weight; tuser = found flag
//   cfg_     | write     | cfg_wr_en                  | min_weight
//
// a node with no crossing to test passes idle, diff and done only; a node whose crossing passes
// the weight test uses one shared restoring divider for the 31-bit weight and then the 32-bit
// interpolation quotient, multiplying in between; a saturated weight skips the first division.
// rst_n is synchronous; reset clears the run state and sets min_weight to 168.
// a last node waits in its final state while the output register still holds a result.
`timescale 1ns / 1ps

module grid_root_select_by_weight
  import grsw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // node_freq [31:0], node_sigma [63:32], node_residual [95:64]
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // root_energy [31:0], root_weight [62:32], zero [63]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // root_found [0]
  output logic                   out_tuser,
  input  logic                   cfg_wr_en,
  input  logic [MIN_W_W-1:0]     cfg_wr_data
);

  state_t                     state_r, state_nxt;
  logic signed [WORD_W-1:0]   cur_freq_r, cur_freq_nxt;
  logic signed [WORD_W-1:0]   cur_sigma_r, cur_sigma_nxt;
  logic signed [WORD_W-1:0]   cur_res_r, cur_res_nxt;
  logic                       cur_last_r, cur_last_nxt;
  logic signed [WORD_W-1:0]   prev_freq_r, prev_freq_nxt;
  logic signed [WORD_W-1:0]   prev_sigma_r, prev_sigma_nxt;
  logic signed [WORD_W-1:0]   prev_res_r, prev_res_nxt;
  logic                       have_prev_r, have_prev_nxt;
  logic signed [DIFF_W-1:0]   df_r, df_nxt;
  logic signed [DIFF_W-1:0]   dt_r, dt_nxt;
  logic signed [DEN_W-1:0]    den_r, den_nxt;
  logic [WORD_W-1:0]          mag_df_r, mag_df_nxt;
  logic [WORD_W-1:0]          mag_t0_r, mag_t0_nxt;
  logic [WORD_W-1:0]          mag_dt_r, mag_dt_nxt;
  logic                       q_neg_r, q_neg_nxt;
  logic                       wrong_sign_r, wrong_sign_nxt;
  logic [DIFF_W-1:0]          rem_r, rem_nxt;
  logic [WORD_W-1:0]          quo_r, quo_nxt;
  logic [DIFF_W-1:0]          div_r, div_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [WEIGHT_W-1:0]        w_r, w_nxt;
  logic [WEIGHT_W-1:0]        best_w_r, best_w_nxt;
  logic signed [WORD_W-1:0]   best_e_r, best_e_nxt;
  logic                       any_r, any_nxt;
  logic [MIN_W_W-1:0]         min_w_r, min_w_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0]   out_energy_r, out_energy_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [WEIGHT_W-1:0]        out_weight_r, out_weight_nxt;

  // shared divider step
  logic [DIFF_W:0]            rem_sh;
  logic                       div_ge;
  logic [DIFF_W:0]            rem_sub;
  logic [DIFF_W-1:0]          step_rem;
  logic [WORD_W-1:0]          step_quo;

  // node difference and setup terms
  logic signed [DIFF_W-1:0]   df_c, ds_c, dt_c;
  logic signed [DEN_W-1:0]    den_c;
  logic                       cross_c;
  logic [DIFF_W-1:0]          mag_df_w, mag_dt_w;
  logic [DEN_W-1:0]           mag_den_w;
  logic [WORD_W:0]            mag_t0_w;
  logic                       sat_c;
  logic                       reject_c;
  logic [PROD_W-1:0]          prod_c;
  logic signed [DEN_W-1:0]    q_c, pole_c;
  logic signed [WORD_W-1:0]   pole_sat;

  assign rem_sh   = {rem_r, quo_r[WORD_W-1]};
  assign div_ge   = rem_sh >= {1'b0, div_r};
  assign rem_sub  = rem_sh - {1'b0, div_r};
  assign step_rem = div_ge ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
  assign step_quo = {quo_r[WORD_W-2:0], div_ge};

  assign df_c  = DIFF_W'(cur_freq_r) - DIFF_W'(prev_freq_r);
  assign ds_c  = DIFF_W'(cur_sigma_r) - DIFF_W'(prev_sigma_r);
  assign dt_c  = DIFF_W'(cur_res_r) - DIFF_W'(prev_res_r);
  assign den_c = DEN_W'(df_c) - DEN_W'(ds_c);
  assign cross_c = (prev_res_r[WORD_W-1] && !cur_res_r[WORD_W-1] && (cur_res_r != '0))
                || (!prev_res_r[WORD_W-1] && (prev_res_r != '0) && cur_res_r[WORD_W-1]);

  assign mag_df_w  = df_r[DIFF_W-1] ? DIFF_W'(-df_r) : DIFF_W'(df_r);
  assign mag_dt_w  = dt_r[DIFF_W-1] ? DIFF_W'(-dt_r) : DIFF_W'(dt_r);
  assign mag_den_w = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
  assign mag_t0_w  = prev_res_r[WORD_W-1] ? (WORD_W+1)'(-(WORD_W+1)'(prev_res_r))
                                          : (WORD_W+1)'(prev_res_r);
  // weight saturates when |df| * 2^24 >= |den| * 2^31
  assign sat_c = {{(SAT_SHIFT+1){1'b0}}, mag_df_w} >= {mag_den_w, {SAT_SHIFT{1'b0}}};

  assign reject_c = (wrong_sign_r && (w_r != '0))
                 || ({{(WEIGHT_W-MIN_W_W){1'b0}}, min_w_r} > w_r)
                 || (any_r && (w_r <= best_w_r));

  assign prod_c = PROD_W'(mag_t0_r) * PROD_W'(mag_df_r);

  assign q_c    = q_neg_r ? -DEN_W'({1'b0, quo_r}) : DEN_W'({1'b0, quo_r});
  assign pole_c = DEN_W'(prev_freq_r) - q_c;
  always_comb begin
    if (pole_c > DEN_W'(signed'({1'b0, {(WORD_W-1){1'b1}}}))) begin
      pole_sat = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (pole_c < -DEN_W'(signed'({2'b01, {(WORD_W-1){1'b0}}}))) begin
      pole_sat = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      pole_sat = pole_c[WORD_W-1:0];
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {1'b0, out_weight_r, out_energy_r};

  always_comb begin
    state_nxt      = state_r;
    cur_freq_nxt   = cur_freq_r;
    cur_sigma_nxt  = cur_sigma_r;
    cur_res_nxt    = cur_res_r;
    cur_last_nxt   = cur_last_r;
    prev_freq_nxt  = prev_freq_r;
    prev_sigma_nxt = prev_sigma_r;
    prev_res_nxt   = prev_res_r;
    have_prev_nxt  = have_prev_r;
    df_nxt         = df_r;
    dt_nxt         = dt_r;
    den_nxt        = den_r;
    mag_df_nxt     = mag_df_r;
    mag_t0_nxt     = mag_t0_r;
    mag_dt_nxt     = mag_dt_r;
    q_neg_nxt      = q_neg_r;
    wrong_sign_nxt = wrong_sign_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;
    w_nxt          = w_r;
    best_w_nxt     = best_w_r;
    best_e_nxt     = best_e_r;
    any_nxt        = any_r;
    min_w_nxt      = cfg_wr_en ? cfg_wr_data : min_w_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_energy_nxt = out_energy_r;
    out_found_nxt  = out_found_r;
    out_weight_nxt = out_weight_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cur_freq_nxt  = in_tdata[WORD_W-1:0];
          cur_sigma_nxt = in_tdata[2*WORD_W-1:WORD_W];
          cur_res_nxt   = in_tdata[3*WORD_W-1:2*WORD_W];
          cur_last_nxt  = in_tlast;
          state_nxt     = S_DIFF;
        end
      end
      S_DIFF: begin
        df_nxt    = df_c;
        dt_nxt    = dt_c;
        den_nxt   = den_c;
        state_nxt = (have_prev_r && cross_c) ? S_WSET : S_DONE;
      end
      S_WSET: begin
        mag_df_nxt     = mag_df_w[WORD_W-1:0];
        mag_dt_nxt     = mag_dt_w[WORD_W-1:0];
        mag_t0_nxt     = mag_t0_w[WORD_W-1:0];
        q_neg_nxt      = prev_res_r[WORD_W-1] ^ df_r[DIFF_W-1] ^ dt_r[DIFF_W-1];
        wrong_sign_nxt = df_r[DIFF_W-1] != den_r[DEN_W-1];
        div_nxt        = mag_den_w[DIFF_W-1:0];
        if (den_r == '0) begin
          state_nxt = S_DONE;
        end else if (sat_c) begin
          w_nxt     = WEIGHT_MAX;
          state_nxt = S_WCHK;
        end else begin
          // quotient fits 31 bits, so start with the top dividend bits preloaded
          rem_nxt   = DIFF_W'(mag_df_w[WORD_W-1:SAT_SHIFT]);
          quo_nxt   = {mag_df_w[SAT_SHIFT-1:0], {(WORD_W-SAT_SHIFT){1'b0}}};
          cnt_nxt   = WDIV_STEPS;
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          w_nxt     = step_quo[WEIGHT_W-1:0];
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        state_nxt = reject_c ? S_DONE : S_MUL;
      end
      S_MUL: begin
        // quotient is bounded by |df|, so the high product half is already below |dt|
        rem_nxt   = DIFF_W'(prod_c[PROD_W-1:WORD_W]);
        quo_nxt   = prod_c[WORD_W-1:0];
        div_nxt   = {1'b0, mag_dt_r};
        cnt_nxt   = QDIV_STEPS;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        rem_nxt = step_rem;
        quo_nxt = step_quo;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_POLE;
        end
      end
      S_POLE: begin
        best_e_nxt = pole_sat;
        best_w_nxt = w_r;
        any_nxt    = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!cur_last_r) begin
          prev_freq_nxt  = cur_freq_r;
          prev_sigma_nxt = cur_sigma_r;
          prev_res_nxt   = cur_res_r;
          have_prev_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = any_r;
          out_energy_nxt = any_r ? best_e_r : '0;
          out_weight_nxt = any_r ? best_w_r : '0;
          prev_freq_nxt  = '0;
          prev_sigma_nxt = '0;
          prev_res_nxt   = '0;
          have_prev_nxt  = 1'b0;
          best_w_nxt     = '0;
          best_e_nxt     = '0;
          any_nxt        = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      any_r       <= 1'b0;
      min_w_r     <= MIN_WEIGHT_RESET;
      out_valid_r <= 1'b0;
      prev_freq_r  <= '0;
      prev_sigma_r <= '0;
      prev_res_r   <= '0;
      best_w_r     <= '0;
      best_e_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      any_r       <= any_nxt;
      min_w_r     <= min_w_nxt;
      out_valid_r <= out_valid_nxt;
      prev_freq_r  <= prev_freq_nxt;
      prev_sigma_r <= prev_sigma_nxt;
      prev_res_r   <= prev_res_nxt;
      best_w_r     <= best_w_nxt;
      best_e_r     <= best_e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_freq_r     <= cur_freq_nxt;
    cur_sigma_r    <= cur_sigma_nxt;
    cur_res_r      <= cur_res_nxt;
    cur_last_r     <= cur_last_nxt;
    df_r           <= df_nxt;
    dt_r           <= dt_nxt;
    den_r          <= den_nxt;
    mag_df_r       <= mag_df_nxt;
    mag_t0_r       <= mag_t0_nxt;
    mag_dt_r       <= mag_dt_nxt;
    q_neg_r        <= q_neg_nxt;
    wrong_sign_r   <= wrong_sign_nxt;
    rem_r          <= rem_nxt;
    quo_r          <= quo_nxt;
    div_r          <= div_nxt;
    cnt_r          <= cnt_nxt;
    w_r            <= w_nxt;
    out_energy_r   <= out_energy_nxt;
    out_found_r    <= out_found_nxt;
    out_weight_r   <= out_weight_nxt;
  end

endmodule
